// File: hw/rtl/ftd_pkg.sv
// ----------------------------------------------------------------------------
// FAT table decoder package
// Shared types, codes and constants for the allocation table decoder.
// ----------------------------------------------------------------------------
package ftd_pkg;

  // Default width of the internal cluster counters.
  localparam int unsigned CLUSTER_INDEX_BITS_DEF = 28;

  // Fixed field widths of the result items.
  localparam int unsigned ClusterW  = 28;
  localparam int unsigned EntryW    = 32;
  localparam int unsigned LengthW   = 29;

  // Header bytes and entry constants.
  localparam logic [7:0]  HdrFill     = 8'hff;
  localparam logic [7:0]  HdrDirty16  = 8'h7f;
  localparam logic [7:0]  HdrDirty32  = 8'h07;
  localparam logic [7:0]  HdrNibble   = 8'h0f;
  localparam logic [31:0] Mask12      = 32'h0000_0fff;
  localparam logic [31:0] Mask16      = 32'h0000_ffff;
  localparam logic [31:0] Mask32      = 32'h0fff_ffff;
  localparam logic [31:0] ReservedMin = 32'hffff_fff6;
  localparam logic [3:0]  HdrLen12    = 4'd3;
  localparam logic [3:0]  HdrLen16    = 4'd4;
  localparam logic [3:0]  HdrLen32    = 4'd8;

  typedef enum logic [1:0] {
    FAT12 = 2'd0,
    FAT16 = 2'd1,
    FAT32 = 2'd2
  } fat_kind_e;

  typedef enum logic [1:0] {
    RK_ENTRY = 2'd0,
    RK_RUN   = 2'd1,
    RK_FINAL = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_CLEAN = 2'd1,
    ST_BAD_SIG   = 2'd2,
    ST_SHORT     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_FAT_TYPE      = 2'd0,
    REG_MEDIA_BYTE    = 2'd1,
    REG_CLUSTER_COUNT = 2'd2
  } reg_index_e;

  // Slots of one step bundle, in the order they are delivered.
  localparam int unsigned SlotEntry = 0;
  localparam int unsigned SlotRun   = 1;
  localparam int unsigned SlotFinal = 2;

  typedef struct packed {
    logic [1:0]  fat_type;
    logic [7:0]  media_byte;
    logic [28:0] cluster_count;
  } cfg_t;

  // All results produced by one table byte.
  typedef struct packed {
    logic [2:0]          present;
    logic [ClusterW-1:0] cluster;
    logic [EntryW-1:0]   entry_value;
    logic [ClusterW-1:0] run_start;
    logic [LengthW-1:0]  run_length;
    status_e             status;
    logic [LengthW-1:0]  free_count;
  } step_t;

endpackage

// File: hw/rtl/fat_table_decoder_free_runs.sv
// An accepted byte's results are registered into the queue behind earlier bundles.
// Throughput: one table byte per cycle while the two-bundle result queue has room;
// a byte that yields results (1 to 3 of them) holds a queue slot until all are taken.
// Configuration writes are taken in any cycle, with no wait.
// Reset (rst_ni low, asynchronous) restores register defaults FAT16, media 0xf8,
// cluster count 2, and clears the stream state and the result queue.
// ----------------------------------------------------------------------------
// FAT allocation table decoder
// Checks the table signature, decodes entries and reports free-cluster runs.
// ----------------------------------------------------------------------------
module fat_table_decoder_free_runs
  import ftd_pkg::*;
#(
  parameter int unsigned CLUSTER_INDEX_BITS = CLUSTER_INDEX_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [28:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_table_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [27:0] cluster_o,
  output logic [31:0] entry_value_o,
  output logic [27:0] run_start_o,
  output logic [28:0] run_length_o,
  output logic [1:0]  status_o,
  output logic [28:0] free_count_o,
  output logic        last_o
);

  cfg_t  cfg_q;
  logic  accept;
  logic  push;
  logic  space;
  step_t step;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = space;
  assign accept      = in_valid_i && space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fat_type      <= FAT16;
      cfg_q.media_byte    <= 8'd248;
      cfg_q.cluster_count <= 29'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FAT_TYPE:      cfg_q.fat_type      <= cfg_data_i[1:0];
        REG_MEDIA_BYTE:    cfg_q.media_byte    <= cfg_data_i[7:0];
        REG_CLUSTER_COUNT: cfg_q.cluster_count <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ftd_decode #(
    .CLUSTER_INDEX_BITS(CLUSTER_INDEX_BITS)
  ) u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .end_of_table_i (end_of_table_i),
    .step_o         (step),
    .push_o         (push)
  );

  ftd_outbuf u_outbuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .step_i        (step),
    .space_o       (space),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .cluster_o     (cluster_o),
    .entry_value_o (entry_value_o),
    .run_start_o   (run_start_o),
    .run_length_o  (run_length_o),
    .status_o      (status_o),
    .free_count_o  (free_count_o),
    .last_o        (last_o)
  );

endmodule

// File: hw/rtl/ftd_decode.sv
// ----------------------------------------------------------------------------
// FAT table decoder: byte decode stage
// Header check, entry assembly, free-run tracking and end-of-table status,
// producing the bundle of results for each accepted byte.
// ----------------------------------------------------------------------------
module ftd_decode
  import ftd_pkg::*;
#(
  parameter int unsigned CLUSTER_INDEX_BITS = CLUSTER_INDEX_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_table_i,
  output step_t      step_o,
  output logic       push_o
);

  localparam int unsigned CiW = CLUSTER_INDEX_BITS;
  localparam logic [CiW-1:0] IndexCap = '1;
  localparam logic [CiW-1:0] FirstCluster = CiW'(2);

  logic [3:0]     hpos_q, hpos_d;
  logic [1:0]     phase_q, phase_d;
  logic [23:0]    part_q, part_d;
  logic [CiW-1:0] cidx_q, cidx_d;
  logic [CiW-1:0] run_q, run_d;
  logic [CiW-1:0] free_q, free_d;
  status_e        err_q, err_d;
  logic           clean_q, clean_d;
  logic           dirty_q, dirty_d;

  fat_kind_e      fat;
  logic [3:0]     hlen;
  logic [CiW-1:0] limit;
  logic           hdr_byte;
  logic           hc, hd;
  logic           take;
  logic [31:0]    raw, mask, ent;
  step_t          step;

  always_comb begin
    case (cfg_i.fat_type)
      FAT16:   fat = FAT16;
      FAT32:   fat = FAT32;
      default: fat = FAT12;
    endcase
    case (fat)
      FAT16:   begin hlen = HdrLen16; mask = Mask16; end
      FAT32:   begin hlen = HdrLen32; mask = Mask32; end
      default: begin hlen = HdrLen12; mask = Mask12; end
    endcase
    if (cfg_i.cluster_count < LengthW'(IndexCap)) begin
      limit = cfg_i.cluster_count[CiW-1:0];
    end else begin
      limit = IndexCap;
    end
  end

  // Per-byte header match against the clean and the dirty-shutdown patterns.
  always_comb begin
    if (hpos_q == 4'd0) begin
      hc = (data_byte_i == cfg_i.media_byte);
      hd = hc;
    end else if (hpos_q <= 4'd2) begin
      hc = (data_byte_i == HdrFill);
      hd = hc;
    end else if (fat == FAT16) begin
      hc = (data_byte_i == HdrFill);
      hd = (data_byte_i == HdrDirty16);
    end else if (hpos_q == 4'd3) begin
      hc = ((data_byte_i & HdrNibble) == HdrNibble);
      hd = (data_byte_i == HdrNibble);
    end else if (hpos_q <= 4'd6) begin
      hc = (data_byte_i == HdrFill);
      hd = hc;
    end else begin
      hc = ((data_byte_i & HdrNibble) == HdrNibble);
      hd = (data_byte_i == HdrDirty32);
    end
  end

  always_comb begin
    hpos_d   = hpos_q;
    phase_d  = phase_q;
    part_d   = part_q;
    cidx_d   = cidx_q;
    run_d    = run_q;
    free_d   = free_q;
    err_d    = err_q;
    clean_d  = clean_q;
    dirty_d  = dirty_q;
    step     = '0;
    hdr_byte = 1'b0;
    take     = 1'b0;
    raw      = '0;
    ent      = '0;

    if (err_q == ST_OK) begin
      if (hpos_q < hlen) begin
        hdr_byte = 1'b1;
        clean_d  = clean_q & hc;
        dirty_d  = dirty_q & hd;
        hpos_d   = hpos_q + 4'd1;
      end
      if (hpos_d >= hlen && !clean_d) begin
        err_d = (dirty_d && fat != FAT12) ? ST_NOT_CLEAN : ST_BAD_SIG;
      end else if (!hdr_byte && cidx_q < limit) begin
        case (fat)
          FAT32: begin
            phase_d = phase_q + 2'd1;
            case (phase_q)
              2'd0: part_d = part_q | {16'd0, data_byte_i};
              2'd1: part_d = part_q | {8'd0, data_byte_i, 8'd0};
              2'd2: part_d = part_q | {data_byte_i, 16'd0};
              default: begin
                take    = 1'b1;
                raw     = {data_byte_i, part_q};
                phase_d = 2'd0;
                part_d  = '0;
              end
            endcase
          end
          FAT16: begin
            if (phase_q >= 2'd1) begin
              take    = 1'b1;
              raw     = {16'd0, data_byte_i, part_q[7:0]};
              phase_d = 2'd0;
              part_d  = '0;
            end else begin
              part_d  = {16'd0, data_byte_i};
              phase_d = 2'd1;
            end
          end
          default: begin
            // Two 12-bit entries share three bytes; the middle byte is split.
            case (phase_q)
              2'd0: begin
                part_d  = {16'd0, data_byte_i};
                phase_d = 2'd1;
              end
              2'd1: begin
                part_d  = {8'd0, data_byte_i, part_q[7:0]};
                phase_d = 2'd2;
                take    = 1'b1;
                raw     = {20'd0, data_byte_i[3:0], part_q[7:0]};
              end
              default: begin
                phase_d = 2'd0;
                part_d  = '0;
                take    = 1'b1;
                raw     = {20'd0, data_byte_i, part_q[15:12]};
              end
            endcase
          end
        endcase
      end
    end

    if (take) begin
      ent = raw & mask;
      if (ent >= (ReservedMin & mask)) begin
        ent = ent | ~mask;
      end
      step.present[SlotEntry] = 1'b1;
      step.cluster            = ClusterW'(cidx_q);
      step.entry_value        = ent;
      if (ent == '0) begin
        if (run_q == '0) begin
          run_d = cidx_q;
        end
        free_d = free_q + CiW'(1);
      end else if (run_q != '0) begin
        step.present[SlotRun] = 1'b1;
        step.run_start        = ClusterW'(run_q);
        step.run_length       = LengthW'(cidx_q - run_q);
        run_d                 = '0;
      end
      cidx_d = cidx_q + CiW'(1);
    end

    if (end_of_table_i) begin
      if (run_d != '0) begin
        step.present[SlotRun] = 1'b1;
        step.run_start        = ClusterW'(run_d);
        step.run_length       = LengthW'(cidx_d - run_d);
      end
      step.present[SlotFinal] = 1'b1;
      step.free_count         = LengthW'(free_d);
      if (err_d != ST_OK) begin
        step.status = err_d;
      end else if (hpos_d < hlen || cidx_d < limit) begin
        step.status = ST_SHORT;
      end else begin
        step.status = ST_OK;
      end
      hpos_d  = '0;
      phase_d = '0;
      part_d  = '0;
      cidx_d  = FirstCluster;
      run_d   = '0;
      free_d  = '0;
      err_d   = ST_OK;
      clean_d = 1'b1;
      dirty_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpos_q  <= '0;
      phase_q <= '0;
      part_q  <= '0;
      cidx_q  <= FirstCluster;
      run_q   <= '0;
      free_q  <= '0;
      err_q   <= ST_OK;
      clean_q <= 1'b1;
      dirty_q <= 1'b1;
    end else if (accept_i) begin
      hpos_q  <= hpos_d;
      phase_q <= phase_d;
      part_q  <= part_d;
      cidx_q  <= cidx_d;
      run_q   <= run_d;
      free_q  <= free_d;
      err_q   <= err_d;
      clean_q <= clean_d;
      dirty_q <= dirty_d;
    end
  end

  assign step_o = step;
  assign push_o = accept_i && (step.present != '0);

  a_cidx_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cidx_q >= FirstCluster)
    else $error("cluster index fell below the first data cluster");

  a_run_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q != '0) |-> (run_q < cidx_q))
    else $error("open free run does not lie behind the cluster index");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= (cidx_q - FirstCluster))
    else $error("free count exceeds the clusters decoded");

endmodule

// File: hw/rtl/ftd_outbuf.sv
// ----------------------------------------------------------------------------
// FAT table decoder: result queue
// Two-deep queue of per-byte bundles, delivered one result per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module ftd_outbuf
  import ftd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  step_t       step_i,
  output logic        space_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [27:0] cluster_o,
  output logic [31:0] entry_value_o,
  output logic [27:0] run_start_o,
  output logic [28:0] run_length_o,
  output logic [1:0]  status_o,
  output logic [28:0] free_count_o,
  output logic        last_o
);

  step_t      mem [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q, count_d;
  logic [2:0] sent_q;
  step_t      head;
  logic [2:0] pending, cur, rest;
  logic       pop, head_done;

  assign head    = mem[rd_q];
  assign pending = (count_q != 2'd0) ? (head.present & ~sent_q) : 3'b000;

  always_comb begin
    cur           = 3'b000;
    result_kind_o = RK_ENTRY;
    cluster_o     = '0;
    entry_value_o = '0;
    run_start_o   = '0;
    run_length_o  = '0;
    status_o      = ST_OK;
    free_count_o  = '0;
    if (pending[SlotEntry]) begin
      cur[SlotEntry] = 1'b1;
      result_kind_o  = RK_ENTRY;
      cluster_o      = head.cluster;
      entry_value_o  = head.entry_value;
    end else if (pending[SlotRun]) begin
      cur[SlotRun]  = 1'b1;
      result_kind_o = RK_RUN;
      run_start_o   = head.run_start;
      run_length_o  = head.run_length;
    end else if (pending[SlotFinal]) begin
      cur[SlotFinal] = 1'b1;
      result_kind_o  = RK_FINAL;
      status_o       = head.status;
      free_count_o   = head.free_count;
    end
  end

  assign rest        = pending & ~cur;
  assign last_o      = (rest == 3'b000);
  assign out_valid_o = (pending != 3'b000);
  assign pop         = out_valid_o && out_ready_i;
  assign head_done   = pop && last_o;
  assign space_o     = (count_q != 2'd2);

  always_comb begin
    count_d = count_q;
    if (push_i && !head_done) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && head_done) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= step_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= '0;
      sent_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (head_done) begin
        rd_q   <= ~rd_q;
        sent_q <= '0;
      end else if (pop) begin
        sent_q <= sent_q | cur;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("result queue holds more than two bundles");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != 2'd2))
    else $error("bundle pushed into a full result queue");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(cur))
    else $error("more than one result selected for delivery");

  a_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !head_done) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue fill did not follow a push");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FAT table decoder testbench
// Streams allocation tables through the decoder under random back-pressure,
// predicts every entry, free run and final status, and checks them in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ftd_pkg::*;

  localparam logic [31:0] IndexCap  = (32'd1 << CLUSTER_INDEX_BITS_DEF) - 32'd1;
  localparam logic [1:0]  RegUnused = 2'd3;
  localparam int unsigned RandomBytes = 420;

  typedef struct packed {
    result_kind_e kind;
    logic [27:0]  cluster;
    logic [31:0]  entry_value;
    logic [27:0]  run_start;
    logic [28:0]  run_length;
    status_e      status;
    logic [28:0]  free_count;
    logic         is_last;
  } table_result_t;

  typedef struct packed {
    logic        is_wr;
    logic [1:0]  idx;
    logic [28:0] val;
    logic [7:0]  b;
    logic        eot;
    logic        chk;
    status_e     st;
    logic [28:0] fc;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [28:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        end_of_table_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [27:0] cluster_o;
  logic [31:0] entry_value_o;
  logic [27:0] run_start_o;
  logic [28:0] run_length_o;
  logic [1:0]  status_o;
  logic [28:0] free_count_o;
  logic        last_o;

  fat_table_decoder_free_runs dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .end_of_table_i(end_of_table_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .cluster_o     (cluster_o),
    .entry_value_o (entry_value_o),
    .run_start_o   (run_start_o),
    .run_length_o  (run_length_o),
    .status_o      (status_o),
    .free_count_o  (free_count_o),
    .last_o        (last_o)
  );

  always #10 clk_i = ~clk_i;

  // Register copies and stream state of the decoder as the checker sees it.
  logic [1:0]    reg_type;
  logic [7:0]    reg_media;
  logic [28:0]   reg_count;
  int unsigned   hdr_pos;
  int unsigned   byte_ph;
  logic [31:0]   partial;
  logic [31:0]   cl_idx;
  logic [31:0]   run_open;
  logic [28:0]   free_tot;
  status_e       err_st;
  bit            sig_clean;
  bit            sig_dirty;
  table_result_t step_res [3];
  int            step_n;

  table_result_t pending[$];
  int unsigned   errors = 0;
  int unsigned   random_items = 0;
  int unsigned   gap_pct = 0;
  int unsigned   stall_pct = 0;
  int            ready_hold = 0;
  status_e       seen_status = ST_OK;
  logic [28:0]   seen_free = '0;

  function automatic fat_kind_e eff_type(logic [1:0] r);
    return (r == 2'd3) ? FAT12 : fat_kind_e'(r);
  endfunction

  function automatic void clear_stream();
    hdr_pos   = 0;
    byte_ph   = 0;
    partial   = '0;
    cl_idx    = 32'd2;
    run_open  = '0;
    free_tot  = '0;
    err_st    = ST_OK;
    sig_clean = 1'b1;
    sig_dirty = 1'b1;
  endfunction

  function automatic void model_reset();
    reg_type  = FAT16;
    reg_media = 8'hf8;
    reg_count = 29'd2;
    clear_stream();
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [28:0] val);
    case (idx)
      REG_FAT_TYPE:      reg_type = val[1:0];
      REG_MEDIA_BYTE:    reg_media = val[7:0];
      REG_CLUSTER_COUNT: reg_count = val;
      default: ;
    endcase
  endfunction

  function automatic void emit(result_kind_e k, logic [27:0] cl, logic [31:0] v,
                               logic [27:0] rs, logic [28:0] rl, status_e st,
                               logic [28:0] fc);
    step_res[step_n] = '{k, cl, v, rs, rl, st, fc, 1'b0};
    step_n++;
  endfunction

  function automatic void check_sig(fat_kind_e t, int unsigned pos, logic [7:0] b);
    bit c, d;
    if (pos == 0) begin
      c = (b == reg_media);
      d = c;
    end else if (pos <= 2) begin
      c = (b == HdrFill);
      d = c;
    end else if (t == FAT16) begin
      c = (b == HdrFill);
      d = (b == HdrDirty16);
    end else if (pos == 3) begin
      c = ((b & HdrNibble) == HdrNibble);
      d = (b == HdrNibble);
    end else if (pos <= 6) begin
      c = (b == HdrFill);
      d = c;
    end else begin
      c = ((b & HdrNibble) == HdrNibble);
      d = (b == HdrDirty32);
    end
    sig_clean = sig_clean && c;
    sig_dirty = sig_dirty && d;
  endfunction

  function automatic void emit_entry(fat_kind_e t, logic [31:0] raw);
    logic [31:0] mask, v;
    mask = (t == FAT32) ? Mask32 : (t == FAT16) ? Mask16 : Mask12;
    v = raw & mask;
    // Reserved and end-of-chain markers are widened to all ones above the entry.
    if (v >= (ReservedMin & mask)) v = v | ~mask;
    emit(RK_ENTRY, cl_idx[27:0], v, '0, '0, ST_OK, '0);
    if (v == 0) begin
      if (run_open == 0) run_open = cl_idx;
      free_tot++;
    end else if (run_open != 0) begin
      emit(RK_RUN, '0, '0, run_open[27:0], 29'(cl_idx - run_open), ST_OK, '0);
      run_open = '0;
    end
    cl_idx++;
  endfunction

  // Works out the results of one accepted table byte and queues them.
  function automatic void decode_byte(logic [7:0] b, logic eot);
    fat_kind_e   t;
    logic [31:0] hlen, lim;
    bit          hdr_byte;
    logic [7:0]  hi;
    status_e     st;
    t = eff_type(reg_type);
    hlen = (t == FAT32) ? HdrLen32 : (t == FAT16) ? HdrLen16 : HdrLen12;
    lim = ({3'd0, reg_count} < IndexCap) ? {3'd0, reg_count} : IndexCap;
    step_n = 0;
    if (err_st == ST_OK) begin
      hdr_byte = 1'b0;
      if (hdr_pos < hlen) begin
        check_sig(t, hdr_pos, b);
        hdr_pos++;
        hdr_byte = 1'b1;
      end
      if (hdr_pos >= hlen && !sig_clean) begin
        err_st = (sig_dirty && t != FAT12) ? ST_NOT_CLEAN : ST_BAD_SIG;
      end else if (!hdr_byte && cl_idx < lim) begin
        case (t)
          FAT32: begin
            if (byte_ph >= 3) begin
              emit_entry(t, {b, partial[23:0]});
              byte_ph = 0;
              partial = '0;
            end else begin
              partial = partial | ({24'd0, b} << (8 * byte_ph));
              byte_ph++;
            end
          end
          FAT16: begin
            if (byte_ph >= 1) begin
              emit_entry(t, {16'd0, b, partial[7:0]});
              byte_ph = 0;
              partial = '0;
            end else begin
              partial = {24'd0, b};
              byte_ph = 1;
            end
          end
          default: begin
            // Two 12-bit entries share the middle byte of every three.
            if (byte_ph == 0) begin
              partial = {24'd0, b};
              byte_ph = 1;
            end else if (byte_ph == 1) begin
              partial = {16'd0, b, partial[7:0]};
              byte_ph = 2;
              emit_entry(t, partial & Mask12);
            end else begin
              hi = partial[15:8];
              byte_ph = 0;
              partial = '0;
              emit_entry(t, {20'd0, b, hi[7:4]});
            end
          end
        endcase
      end
    end
    if (eot) begin
      if (run_open != 0) begin
        emit(RK_RUN, '0, '0, run_open[27:0], 29'(cl_idx - run_open), ST_OK, '0);
        run_open = '0;
      end
      if (err_st != ST_OK) st = err_st;
      else if (hdr_pos < hlen || cl_idx < lim) st = ST_SHORT;
      else st = ST_OK;
      emit(RK_FINAL, '0, '0, '0, '0, st, free_tot);
      clear_stream();
    end
    if (step_n > 0) step_res[step_n - 1].is_last = 1'b1;
    for (int i = 0; i < step_n; i++) pending.push_back(step_res[i]);
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result();
    table_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: result kind %0d with nothing expected", $time, result_kind_o);
      errors++;
      return;
    end
    e = pending.pop_front();
    cmp_field("result_kind", e.kind, result_kind_o);
    cmp_field("cluster", e.cluster, cluster_o);
    cmp_field("entry_value", e.entry_value, entry_value_o);
    cmp_field("run_start", e.run_start, run_start_o);
    cmp_field("run_length", e.run_length, run_length_o);
    cmp_field("status", e.status, status_o);
    cmp_field("free_count", e.free_count, free_count_o);
    cmp_field("last", e.is_last, last_o);
    if (result_kind_o == RK_FINAL) begin
      seen_status = status_e'(status_o);
      seen_free = free_count_o;
    end
  endfunction

  // Everything is sampled at the rising edge, before the decoder's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result();
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) decode_byte(data_byte_i, end_of_table_i);
    end
  end

  function automatic int idle_len();
    return ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1);
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 15;
      2:       return 35;
      default: return 70;
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      ready_hold = idle_len() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic put_byte(input logic [7:0] b, input logic eot);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat (idle_len()) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    end_of_table_i <= eot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(negedge clk_i);
    // A byte with no results may still be in flight.
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [28:0] val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_write();
    logic [28:0] val;
    int unsigned sel;
    val = 29'($urandom);
    sel = $urandom_range(19);
    case ($urandom_range(2))
      0: write_reg(REG_FAT_TYPE, val);
      1: begin
        if (sel < 3) val[7:0] = 8'h00;
        else if (sel < 6) val[7:0] = 8'hff;
        else if (sel < 12) val[7:0] = 8'hf8;
        write_reg(REG_MEDIA_BYTE, val);
      end
      default: begin
        case (sel)
          0:       val = '0;
          1:       val = 29'd1;
          2:       val = '1;
          3:       val = 29'h1000_0000;
          4:       val = 29'h0fff_ffff;
          default: val = 29'($urandom_range(12, 2));
        endcase
        write_reg(REG_CLUSTER_COUNT, val);
      end
    endcase
  endtask

  // Builds one table for the current settings: mostly a sound header and a body sized
  // to the cluster count, up to 16 entries, sometimes dirty, corrupted, cut short or padded.
  task automatic send_table();
    logic [7:0]  q[$];
    logic [31:0] ents[$];
    logic [31:0] v, mask;
    fat_kind_e   t;
    int unsigned shape, n_ent, cnt, pick, tail;
    bit          dirty, broken;
    t = eff_type(reg_type);
    mask = (t == FAT32) ? Mask32 : (t == FAT16) ? Mask16 : Mask12;
    shape = $urandom_range(19);
    dirty = (shape >= 14 && shape < 17);
    broken = (shape >= 17);
    q.push_back(reg_media);
    q.push_back(HdrFill);
    q.push_back(HdrFill);
    if (t == FAT16) q.push_back(dirty ? HdrDirty16 : HdrFill);
    if (t == FAT32) begin
      q.push_back(dirty ? HdrNibble : {4'($urandom), HdrNibble[3:0]});
      repeat (3) q.push_back(HdrFill);
      q.push_back(dirty ? HdrDirty32 : {4'($urandom), HdrNibble[3:0]});
    end
    if (broken) q[$urandom_range(q.size() - 1)] = 8'($urandom);
    cnt = reg_count;
    n_ent = (cnt > 2) ? ((cnt - 2 > 16) ? 16 : cnt - 2) : 0;
    for (int i = 0; i < n_ent; i++) begin
      pick = $urandom_range(9);
      if (pick < 4) v = '0;
      else if (pick < 6) v = mask - $urandom_range(9);
      else v = $urandom;
      ents.push_back(v);
    end
    if (t == FAT12 && ents.size() % 2 == 1) ents.push_back($urandom);
    for (int i = 0; i < ents.size(); i++) begin
      v = ents[i];
      if (t == FAT32) begin
        v[31:28] = 4'($urandom);
        q.push_back(v[7:0]);
        q.push_back(v[15:8]);
        q.push_back(v[23:16]);
        q.push_back(v[31:24]);
      end else if (t == FAT16) begin
        q.push_back(v[7:0]);
        q.push_back(v[15:8]);
      end else if (i % 2 == 0) begin
        q.push_back(v[7:0]);
        q.push_back({ents[i + 1][3:0], v[11:8]});
        q.push_back(ents[i + 1][11:4]);
      end
    end
    tail = $urandom_range(9);
    if (tail < 2) begin
      repeat ($urandom_range(3, 1)) if (q.size() > 1) q.delete(q.size() - 1);
    end else if (tail < 4) begin
      repeat ($urandom_range(3, 1)) q.push_back(8'($urandom));
    end
    foreach (q[k]) put_byte(q[k], k == q.size() - 1);
    random_items += q.size();
  endtask

  // Directed tables; the final status is typed in where it is plain to see.
  plan_row_t plan[$] = '{
    // Reset settings: FAT16, media 0xf8, two clusters, so the header is the table.
    '{0, 0, 0, 8'hf8, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'hff, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'hff, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'hff, 1, 1, ST_OK, 0},
    '{1, REG_CLUSTER_COUNT, 3, 0, 0, 0, ST_OK, 0},
    // Dirty-shutdown pattern; the byte after it is ignored.
    '{0, 0, 0, 8'hf8, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'hff, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'hff, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'h7f, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'h12, 1, 1, ST_NOT_CLEAN, 0},
    // One free cluster, a byte past the limit, and the open run flushed at the end.
    '{0, 0, 0, 8'hf8, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'hff, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'hff, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'hff, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'h00, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'h00, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'h55, 1, 1, ST_OK, 1},
    '{1, REG_FAT_TYPE, FAT12, 0, 0, 0, ST_OK, 0},
    '{1, REG_MEDIA_BYTE, 29'h0f0, 0, 0, 0, ST_OK, 0},
    // Table ending inside the header is short even with a bad byte in it.
    '{0, 0, 0, 8'hf0, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'h7f, 1, 1, ST_SHORT, 0},
    // FAT12 has no dirty pattern, so a wrong media byte is a bad signature.
    '{0, 0, 0, 8'h00, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'hff, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'hff, 1, 1, ST_BAD_SIG, 0},
    '{1, RegUnused, 29'h1fff_ffff, 0, 0, 0, ST_OK, 0},
    '{1, REG_FAT_TYPE, FAT32, 0, 0, 0, ST_OK, 0},
    '{1, REG_MEDIA_BYTE, 29'h0f8, 0, 0, 0, ST_OK, 0},
    // Header cut short by a type change part way through.
    '{0, 0, 0, 8'hf8, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'hff, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'hff, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'hff, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'hff, 0, 0, ST_OK, 0},
    '{1, REG_FAT_TYPE, FAT16, 0, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'h34, 0, 0, ST_OK, 0},
    '{0, 0, 0, 8'h12, 1, 1, ST_OK, 0}
  };

  initial begin
    plan_row_t row;
    model_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    gap_pct = 20;
    stall_pct = 20;
    foreach (plan[r]) begin
      row = plan[r];
      if (row.is_wr) begin
        write_reg(row.idx, row.val);
      end else begin
        put_byte(row.b, row.eot);
        if (row.chk) begin
          wait_drained();
          if (seen_status !== row.st || seen_free !== row.fc) begin
            $display("%0t: final status expected %0d/%0d got %0d/%0d", $time,
                     row.st, row.fc, seen_status, seen_free);
            errors++;
          end
        end
      end
    end
    while (random_items < RandomBytes) begin
      gap_pct = pick_pct();
      stall_pct = pick_pct();
      repeat ($urandom_range(3)) random_write();
      repeat ($urandom_range(3, 1)) send_table();
    end
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
